// ===== sv/hmbs_pkg.sv =====
// ---------------------------------------------------------------------------
// hmbs_pkg: shared types and constants for the heightmap bilinear sampler
// Field widths, request and register codes, reset values and the control
// word that drives the banked sample store.
// ---------------------------------------------------------------------------
`default_nettype none

package hmbs_pkg;

  // Fixed field widths of the input and result words.
  localparam int COORD_W  = 8;
  localparam int SAMPLE_W = 8;
  localparam int QPOS_W   = 18;
  localparam int HEIGHT_W = 24;
  localparam int DIM_W    = 9;
  localparam int SCALE_W  = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;

  localparam logic [DIM_W-1:0]   GRID_COLS_RST    = 9'd256;
  localparam logic [DIM_W-1:0]   GRID_ROWS_RST    = 9'd256;
  localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 16'd1966;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Number of store banks, selected by {row parity, column parity}.
  localparam int NUM_BANKS = 4;

  // Control word from the datapath to the sample store.
  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_bank;
    logic       rd_en;
  } hmbs_mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/heightmap_bilinear_sampler.sv =====
// ---------------------------------------------------------------------------
// heightmap_bilinear_sampler: bilinear height lookup on an 8-bit grid
// Load words write one sample; query words return the interpolated height
// at a Q10.8 position, scaled by a Q0.16 factor, as Q8.16.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Payload                                   | Flow
//  --------+-----------+-------------------------------------------+--------------
//  in_*    | input     | tuser req_type; tdata load/query fields   | valid/ready
//  out_*   | output    | tuser in_range; tdata height_out          | valid/ready
//  cfg_*   | input     | index + data, grid size and height scale  | write enable
//
//  One word is taken per cycle while the skid register is empty, loads and
//  queries alike; a query result passes through the bank read, x blend,
//  z blend, then scale into the output register.
//  The four banked sample memories give every query its four neighbors in
//  a single read. Loads produce no result.
//  Reset clears control state only; samples are undefined until loaded.
//  When the output stalls, a skid register catches one result; while it is
//  occupied the pipeline holds and in_tready is low.
// ---------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input stream.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // load_col, load_row, sample, query_x, query_z, zero fill
  input  wire         in_tuser,   // req_type
  // Result stream.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // height_out
  output logic        out_tuser,  // in_range
  // Configuration writes.
  input  wire         cfg_we,
  input  wire  [hmbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [hmbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QI   = hmbs_pkg::QPOS_W - FRAC_BITS;
  localparam int CMPW = (QI > 11) ? QI : 11;
  localparam int CW   = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 2;
  localparam int RW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 2;
  localparam int CH   = CW - 1;
  localparam int RH   = RW - 1;
  localparam int AW   = RH + CH;
  localparam int TW   = 8 + FRAC_BITS;
  localparam int MW   = 8 + 2 * FRAC_BITS;
  localparam int PW   = MW + hmbs_pkg::SCALE_W;

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // Configuration registers.
  logic [hmbs_pkg::DIM_W-1:0]   grid_cols_r;
  logic [hmbs_pkg::DIM_W-1:0]   grid_rows_r;
  logic [hmbs_pkg::SCALE_W-1:0] height_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r    <= hmbs_pkg::GRID_COLS_RST;
      grid_rows_r    <= hmbs_pkg::GRID_ROWS_RST;
      height_scale_r <= hmbs_pkg::HEIGHT_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hmbs_pkg::CFG_GRID_COLS:    grid_cols_r    <= cfg_wdata[hmbs_pkg::DIM_W-1:0];
        hmbs_pkg::CFG_GRID_ROWS:    grid_rows_r    <= cfg_wdata[hmbs_pkg::DIM_W-1:0];
        hmbs_pkg::CFG_HEIGHT_SCALE: height_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Grid size saturated to the store dimensions.
  logic [CMPW-1:0] cols_ext, rows_ext, cols_eff, rows_eff;

  assign cols_ext = CMPW'(grid_cols_r);
  assign rows_ext = CMPW'(grid_rows_r);
  assign cols_eff = (cols_ext > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS) : cols_ext;
  assign rows_eff = (rows_ext > CMPW'(MAX_ROWS)) ? CMPW'(MAX_ROWS) : rows_ext;

  // Input word fields.
  logic [7:0]                  ld_col, ld_row, ld_smp;
  logic [hmbs_pkg::QPOS_W-1:0] qx, qz;

  assign ld_col = in_tdata[7:0];
  assign ld_row = in_tdata[15:8];
  assign ld_smp = in_tdata[23:16];
  assign qx     = in_tdata[41:24];
  assign qz     = in_tdata[59:42];

  // Handshake and pipeline enable: the pipe moves while the skid is empty.
  logic skid_v_r;
  logic en;
  logic in_acc;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;

  // Load address and bank.
  logic [CMPW-1:0] lcol, lrow;
  logic [CW-1:0]   lcol_c;
  logic [RW-1:0]   lrow_c;
  logic            ld_ok;

  assign lcol   = CMPW'(ld_col);
  assign lrow   = CMPW'(ld_row);
  assign lcol_c = lcol[CW-1:0];
  assign lrow_c = lrow[RW-1:0];
  assign ld_ok  = (lcol < cols_eff) && (lrow < rows_eff);

  // Query cell, fractions, range test and edge clamps.
  logic [CMPW-1:0]      cx, cz, cx1, cz1;
  logic [FRAC_BITS-1:0] fx, fz;
  logic                 q_inr, q_clx, q_clz;
  logic [CW-1:0]        x0;
  logic [RW-1:0]        z0;
  logic [CW:0]          x0p1;
  logic [RW:0]          z0p1;
  logic [CH-1:0]        col_even, col_odd;
  logic [RH-1:0]        row_even, row_odd;

  assign cx    = CMPW'(qx[hmbs_pkg::QPOS_W-1:FRAC_BITS]);
  assign cz    = CMPW'(qz[hmbs_pkg::QPOS_W-1:FRAC_BITS]);
  assign fx    = qx[FRAC_BITS-1:0];
  assign fz    = qz[FRAC_BITS-1:0];
  assign cx1   = cx + CMPW'(1);
  assign cz1   = cz + CMPW'(1);
  assign q_inr = (cx < cols_eff) && (cz < rows_eff);
  assign q_clx = !(cx1 < cols_eff);
  assign q_clz = !(cz1 < rows_eff);

  // The even neighbor index is (x0+1)/2 and the odd one x0/2.
  assign x0       = cx[CW-1:0];
  assign z0       = cz[RW-1:0];
  assign x0p1     = {1'b0, x0} + (CW+1)'(1);
  assign z0p1     = {1'b0, z0} + (RW+1)'(1);
  assign col_even = x0p1[CH:1];
  assign col_odd  = x0[CW-1:1];
  assign row_even = z0p1[RH:1];
  assign row_odd  = z0[RW-1:1];

  // Store control and addresses.
  hmbs_pkg::hmbs_mem_ctl_t ctl;
  logic [AW-1:0]           wr_addr;
  logic [4*AW-1:0]         rd_addr;
  logic [31:0]             rd_data;

  assign ctl.wr_en   = in_acc && (in_tuser == hmbs_pkg::REQ_LOAD) && ld_ok;
  assign ctl.wr_bank = {lrow_c[0], lcol_c[0]};
  assign ctl.rd_en   = in_acc && (in_tuser == hmbs_pkg::REQ_QUERY);
  assign wr_addr     = {lrow_c[RW-1:1], lcol_c[CW-1:1]};

  always_comb begin
    for (int b = 0; b < hmbs_pkg::NUM_BANKS; b++) begin
      rd_addr[b*AW +: AW] = {(b[1] ? row_odd : row_even), (b[0] ? col_odd : col_even)};
    end
  end

  hmbs_store #(
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_data (ld_smp),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 1: query attributes alongside the bank read.
  logic                 s1_v_r, s1_inr_r, s1_px_r, s1_pz_r, s1_clx_r, s1_clz_r;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      s1_inr_r <= q_inr;
      s1_px_r  <= x0[0];
      s1_pz_r  <= z0[0];
      s1_clx_r <= q_clx;
      s1_clz_r <= q_clz;
      s1_fx_r  <= fx;
      s1_fz_r  <= fz;
    end
  end

  // Pick the four neighbors out of the banks and blend along x.
  logic                 tr, br, lp, rp;
  logic [7:0]           h0, h1, h2, h3;
  logic [FRAC_BITS:0]   wx0;
  logic [TW-1:0]        top_c, bot_c;

  assign tr  = s1_pz_r;
  assign br  = s1_clz_r ? s1_pz_r : !s1_pz_r;
  assign lp  = s1_px_r;
  assign rp  = s1_clx_r ? s1_px_r : !s1_px_r;
  assign h0  = rd_data[{tr, lp}*8 +: 8];
  assign h1  = rd_data[{tr, rp}*8 +: 8];
  assign h2  = rd_data[{br, lp}*8 +: 8];
  assign h3  = rd_data[{br, rp}*8 +: 8];
  assign wx0 = ONE - {1'b0, s1_fx_r};

  assign top_c = TW'(TW'(h0) * TW'(wx0) + TW'(h1) * TW'(s1_fx_r));
  assign bot_c = TW'(TW'(h2) * TW'(wx0) + TW'(h3) * TW'(s1_fx_r));

  // Stage 2: x blends.
  logic                 s2_v_r, s2_inr_r;
  logic [FRAC_BITS-1:0] s2_fz_r;
  logic [TW-1:0]        s2_top_r, s2_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_inr_r <= s1_inr_r;
      s2_fz_r  <= s1_fz_r;
      s2_top_r <= top_c;
      s2_bot_r <= bot_c;
    end
  end

  // Blend along z.
  logic [FRAC_BITS:0] wz0;
  logic [MW-1:0]      mix_c;

  assign wz0   = ONE - {1'b0, s2_fz_r};
  assign mix_c = MW'(MW'(s2_top_r) * MW'(wz0) + MW'(s2_bot_r) * MW'(s2_fz_r));

  // Stage 3: z blend.
  logic          s3_v_r, s3_inr_r;
  logic [MW-1:0] s3_mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_inr_r <= s2_inr_r;
      s3_mix_r <= mix_c;
    end
  end

  // Scale and drop the SCALE_W fraction bits of the factor; out of range gives zero.
  logic [PW-1:0]                 prod_c;
  logic [hmbs_pkg::HEIGHT_W-1:0] hgt_c;
  logic                          new_res;

  assign prod_c  = PW'(s3_mix_r) * PW'(height_scale_r);
  assign hgt_c   = s3_inr_r ? prod_c[PW-1 -: hmbs_pkg::HEIGHT_W] : '0;
  assign new_res = en && s3_v_r;

  // Output register with a one-word skid behind it.
  logic                          out_v_r, out_inr_r, skid_inr_r, take;
  logic [hmbs_pkg::HEIGHT_W-1:0] out_h_r, skid_h_r;

  assign take = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (new_res) begin
      if (!out_v_r || take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r  <= skid_v_r;
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (new_res) begin
      if (!out_v_r || take) begin
        out_h_r   <= hgt_c;
        out_inr_r <= s3_inr_r;
      end else begin
        skid_h_r   <= hgt_c;
        skid_inr_r <= s3_inr_r;
      end
    end else if (take && skid_v_r) begin
      out_h_r   <= skid_h_r;
      out_inr_r <= skid_inr_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_h_r;
  assign out_tuser  = out_inr_r;

  // The skid only fills behind a valid output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without a valid output word");

  // A full skid freezes the pipeline.
  a_hold_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> ($stable(s3_v_r) && $stable(s2_v_r) && $stable(s1_v_r)))
    else $error("pipeline moved while the skid word was held");

  // Every accepted query enters the pipeline.
  a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == hmbs_pkg::REQ_QUERY)) |=> s1_v_r)
    else $error("accepted query lost at the bank read");

  // Out-of-range results carry a zero height.
  a_zero_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("out-of-range result with nonzero height");

endmodule

`default_nettype wire

// ===== sv/hmbs_store.sv =====
// ---------------------------------------------------------------------------
// hmbs_store: four-bank sample store
// Samples are spread over four banks by row and column parity, so the
// four neighbors of any grid cell sit in different banks and are read
// together. One write port for loads, one registered read per bank.
// ---------------------------------------------------------------------------
`default_nettype none

module hmbs_store #(
  parameter int AW = 14
) (
  input  wire                      clk,
  input  wire hmbs_pkg::hmbs_mem_ctl_t ctl,
  input  wire  [AW-1:0]            wr_addr,
  input  wire  [7:0]               wr_data,
  input  wire  [4*AW-1:0]          rd_addr,  // bank 0 in the lowest bits
  output logic [31:0]              rd_data   // bank 0 in the lowest byte
);

  genvar b;
  generate
    for (b = 0; b < hmbs_pkg::NUM_BANKS; b++) begin : g_bank
      logic [7:0] mem [2**AW];
      logic [7:0] rd_q_r;

      // Write on a load, registered read on a query.
      always_ff @(posedge clk) begin
        if (ctl.wr_en && (ctl.wr_bank == 2'(b))) begin
          mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
          rd_q_r <= mem[rd_addr[b*AW +: AW]];
        end
      end

      assign rd_data[b*8 +: 8] = rd_q_r;
    end
  endgenerate

endmodule

`default_nettype wire
